// ===== design/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and codes for the polyphonic voice allocator: voice modes,
// event and action codes, sequencer states and the control structs.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int NOTE_W = 7;
  localparam int VID_W  = 3;

  // one above the highest MIDI note, starting value of the lowest-note search
  localparam logic [NOTE_W:0] NOTE_LO_INIT = 8'd128;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HELD = 2'd1,
    MODE_REL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_ON   = 2'd0,
    OP_OFF  = 2'd1,
    OP_DONE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    HOW_RETRIG = 2'd0,
    HOW_IDLE   = 2'd1,
    HOW_REL    = 2'd2,
    HOW_STEAL  = 2'd3
  } how_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_TAKE    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_FREE    = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SCAN   = 3'd1,
    ST_DECIDE = 3'd2,
    ST_STEAL  = 3'd3,
    ST_PICK   = 3'd4,
    ST_FETCH  = 3'd5,
    ST_UPDATE = 3'd6,
    ST_DONE   = 3'd7
  } state_t;

  typedef struct packed {
    logic clear;
    logic scan;
    logic steal;
  } scan_ctl_t;

  typedef struct packed {
    logic ret;
    logic idle;
    logic rel;
    logic off;
    logic fin;
    logic steal;
  } scan_flags_t;

  typedef struct packed {
    logic fetch;
    logic update;
    logic last;
    logic finish;
  } upd_ctl_t;

endpackage

// ===== design/pva_scan.sv =====
// ----------------------------------------------------------------------------
// pva_scan
// Shared compare unit. Sees one voice per cycle and accumulates the first
// retrigger, idle, releasing and note-off candidates, the lowest and highest
// notes, and in the second pass the oldest voice that may be stolen.
// ----------------------------------------------------------------------------
module pva_scan #(
  parameter int NUM_VOICES = 8,
  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pva_pkg::scan_ctl_t        ctl,
  input  logic [IW-1:0]             idx,
  input  pva_pkg::mode_t            rd_mode,
  input  logic [pva_pkg::NOTE_W-1:0] rd_note,
  input  logic [IW-1:0]             rd_rank,
  input  logic [pva_pkg::NOTE_W-1:0] item_note,
  input  logic [pva_pkg::VID_W-1:0] item_vid,
  output pva_pkg::scan_flags_t      flags,
  output logic [IW-1:0]             ret_idx,
  output logic [IW-1:0]             idle_idx,
  output logic [IW-1:0]             rel_idx,
  output logic [IW-1:0]             off_idx,
  output logic [IW-1:0]             steal_idx
);
  import pva_pkg::*;

  localparam int VCW = (IW > VID_W) ? IW : VID_W;

  scan_flags_t     flags_r;
  logic [IW-1:0]   ret_r, idle_r, rel_r, off_r, steal_r, lo_r, hi_r, best_r;
  logic [NOTE_W:0] lo_n_r;
  logic [NOTE_W-1:0] hi_n_r;

  logic note_eq, vid_eq, cand;

  assign note_eq = (rd_note == item_note);
  assign vid_eq  = (VCW'(idx) == VCW'(item_vid));
  assign cand    = (rd_mode == MODE_HELD) && (idx != lo_r) && (idx != hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      flags_r <= '0;
    end else if (ctl.scan) begin
      if (!flags_r.ret && rd_mode != MODE_IDLE && note_eq) flags_r.ret <= 1'b1;
      if (!flags_r.idle && rd_mode == MODE_IDLE) flags_r.idle <= 1'b1;
      if (!flags_r.rel && rd_mode == MODE_REL) flags_r.rel <= 1'b1;
      if (!flags_r.off && rd_mode == MODE_HELD && note_eq) flags_r.off <= 1'b1;
      if (vid_eq && rd_mode == MODE_REL) flags_r.fin <= 1'b1;
    end else if (ctl.steal) begin
      if (cand) flags_r.steal <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      lo_n_r <= NOTE_LO_INIT;
      hi_n_r <= '0;
    end else if (ctl.scan) begin
      if (!flags_r.ret && rd_mode != MODE_IDLE && note_eq) ret_r <= idx;
      if (!flags_r.idle && rd_mode == MODE_IDLE) idle_r <= idx;
      if (!flags_r.rel && rd_mode == MODE_REL) rel_r <= idx;
      if (!flags_r.off && rd_mode == MODE_HELD && note_eq) off_r <= idx;
      // only consulted when every voice is held, so all voices take part
      if ({1'b0, rd_note} < lo_n_r) begin
        lo_n_r <= {1'b0, rd_note};
        lo_r   <= idx;
      end
      if (idx == '0 || rd_note > hi_n_r) begin
        hi_n_r <= rd_note;
        hi_r   <= idx;
      end
    end else if (ctl.steal) begin
      // ranks of held voices are unique, lowest rank is oldest
      if (cand && (!flags_r.steal || rd_rank < best_r)) begin
        best_r  <= rd_rank;
        steal_r <= idx;
      end
    end
  end

  assign flags     = flags_r;
  assign ret_idx   = ret_r;
  assign idle_idx  = idle_r;
  assign rel_idx   = rel_r;
  assign off_idx   = off_r;
  assign steal_idx = steal_r;

endmodule

// ===== design/pva_seq.sv =====
// ----------------------------------------------------------------------------
// pva_seq
// Sequencer. Steps the voice counter through the scan, steal search and
// update passes and picks the voice and action for each event.
// ----------------------------------------------------------------------------
module pva_seq #(
  parameter int NUM_VOICES = 8,
  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                item_op,
  input  logic [pva_pkg::VID_W-1:0] item_vid,
  input  pva_pkg::scan_flags_t      flags,
  input  logic [IW-1:0]             ret_idx,
  input  logic [IW-1:0]             idle_idx,
  input  logic [IW-1:0]             rel_idx,
  input  logic [IW-1:0]             off_idx,
  input  logic [IW-1:0]             steal_idx,
  input  logic                      out_free,
  output logic [IW-1:0]             cnt,
  output pva_pkg::scan_ctl_t        ctl,
  output pva_pkg::upd_ctl_t         upd,
  output pva_pkg::act_t             act,
  output logic [IW-1:0]             tgt,
  output pva_pkg::how_t             how
);
  import pva_pkg::*;

  state_t        state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  act_t          act_r, act_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  how_t          how_r, how_nxt;

  act_t          dec_act;
  logic [IW-1:0] dec_tgt;
  how_t          dec_how;
  logic          dec_steal;
  logic          cnt_last;

  assign cnt_last = (cnt_r == IW'(NUM_VOICES - 1));

  always_comb begin
    dec_act   = ACT_NONE;
    dec_tgt   = '0;
    dec_how   = HOW_RETRIG;
    dec_steal = 1'b0;
    unique case (item_op)
      OP_ON: begin
        if (flags.ret) begin
          dec_act = ACT_TAKE;
          dec_tgt = ret_idx;
        end else if (flags.idle) begin
          dec_act = ACT_TAKE;
          dec_tgt = idle_idx;
          dec_how = HOW_IDLE;
        end else if (flags.rel) begin
          dec_act = ACT_TAKE;
          dec_tgt = rel_idx;
          dec_how = HOW_REL;
        end else begin
          dec_steal = 1'b1;
        end
      end
      OP_OFF: begin
        if (flags.off) begin
          dec_act = ACT_RELEASE;
          dec_tgt = off_idx;
        end
      end
      OP_DONE: begin
        // fin is only set for a voice that exists
        if (flags.fin) begin
          dec_act = ACT_FREE;
          dec_tgt = IW'(item_vid);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    tgt_nxt   = tgt_r;
    how_nxt   = how_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
        if (cnt_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        act_nxt = dec_act;
        tgt_nxt = dec_tgt;
        how_nxt = dec_how;
        cnt_nxt = dec_tgt;
        if (dec_steal) begin
          state_nxt = ST_STEAL;
          cnt_nxt   = '0;
        end else if (dec_act != ACT_NONE) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_STEAL: begin
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
        if (cnt_last) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (flags.steal) begin
          act_nxt   = ACT_TAKE;
          tgt_nxt   = steal_idx;
          how_nxt   = HOW_STEAL;
          cnt_nxt   = steal_idx;
          state_nxt = ST_FETCH;
        end else begin
          act_nxt   = ACT_NONE;
          tgt_nxt   = '0;
          how_nxt   = HOW_RETRIG;
          state_nxt = ST_DONE;
        end
      end
      ST_FETCH: begin
        cnt_nxt   = '0;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
        if (cnt_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    ctl.clear  = (state_r == ST_IDLE);
    ctl.scan   = (state_r == ST_SCAN);
    ctl.steal  = (state_r == ST_STEAL);
    upd.fetch  = (state_r == ST_FETCH);
    upd.update = (state_r == ST_UPDATE);
    upd.last   = cnt_last;
    upd.finish = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      act_r   <= ACT_NONE;
      tgt_r   <= '0;
      how_r   <= HOW_RETRIG;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      tgt_r   <= tgt_nxt;
      how_r   <= how_nxt;
    end
  end

  assign cnt = cnt_r;
  assign act = act_r;
  assign tgt = tgt_r;
  assign how = how_r;

endmodule

// ===== design/polyphonic_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// Note-on / note-off / release-done events in, one voice grant per event out.
// ----------------------------------------------------------------------------
// One event is handled at a time, and in_stall stays high until it is done.
// The voice file has a single read port: a pass over the voices visits one
// voice a cycle through the shared compare unit. An event makes one scan pass,
// a steal search pass when no voice is free, and, when it takes, releases or
// frees a voice, an update pass that writes the target and ages the held
// voices. Each held voice keeps its rank in the age order. The result sits in
// an output register, so a waiting result does not stall the scan of the next
// event.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator #(
  parameter int NUM_VOICES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [pva_pkg::NOTE_W-1:0] in_note,
  input  logic [pva_pkg::VID_W-1:0] in_voice_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_granted,
  output logic [pva_pkg::VID_W-1:0] out_voice_index,
  output logic [1:0]                out_how
);
  import pva_pkg::*;

  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = $clog2(NUM_VOICES + 1);

  mode_t             mode_r [NUM_VOICES];
  logic [NOTE_W-1:0] vnote_r [NUM_VOICES];
  logic [IW-1:0]     rank_r [NUM_VOICES];
  logic [CW-1:0]     count_r;

  logic [1:0]        op_r;
  logic [NOTE_W-1:0] item_note_r;
  logic [VID_W-1:0]  vid_r;

  logic [IW-1:0]     rv_r;
  logic              was_held_r;

  logic              out_valid_r;
  logic              out_granted_r;
  logic [VID_W-1:0]  out_index_r;
  logic [1:0]        out_how_r;

  scan_ctl_t         ctl;
  scan_flags_t       flags;
  upd_ctl_t          upd;
  act_t              act;
  how_t              how;
  logic [IW-1:0]     cnt, tgt;
  logic [IW-1:0]     ret_idx, idle_idx, rel_idx, off_idx, steal_idx;

  mode_t             rd_mode;
  logic [NOTE_W-1:0] rd_note;
  logic [IW-1:0]     rd_rank;
  logic              out_free;
  logic              in_xfer;
  logic              at_tgt;
  logic              remove;

  assign rd_mode  = mode_r[cnt];
  assign rd_note  = vnote_r[cnt];
  assign rd_rank  = rank_r[cnt];
  assign out_free = !out_valid_r || !out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign at_tgt   = (cnt == tgt);
  // the target leaves the age order when it was held before
  assign remove   = (act == ACT_RELEASE) || (act == ACT_TAKE && was_held_r);

  pva_seq #(.NUM_VOICES(NUM_VOICES)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .item_op   (op_r),
    .item_vid  (vid_r),
    .flags     (flags),
    .ret_idx   (ret_idx),
    .idle_idx  (idle_idx),
    .rel_idx   (rel_idx),
    .off_idx   (off_idx),
    .steal_idx (steal_idx),
    .out_free  (out_free),
    .cnt       (cnt),
    .ctl       (ctl),
    .upd       (upd),
    .act       (act),
    .tgt       (tgt),
    .how       (how)
  );

  pva_scan #(.NUM_VOICES(NUM_VOICES)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .idx       (cnt),
    .rd_mode   (rd_mode),
    .rd_note   (rd_note),
    .rd_rank   (rd_rank),
    .item_note (item_note_r),
    .item_vid  (vid_r),
    .flags     (flags),
    .ret_idx   (ret_idx),
    .idle_idx  (idle_idx),
    .rel_idx   (rel_idx),
    .off_idx   (off_idx),
    .steal_idx (steal_idx)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r        <= in_op;
      item_note_r <= in_note;
      vid_r       <= in_voice_id;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.fetch) begin
      rv_r       <= rd_rank;
      was_held_r <= (rd_mode == MODE_HELD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        mode_r[i] <= MODE_IDLE;
      end
    end else if (upd.update && at_tgt) begin
      case (act)
        ACT_TAKE:    mode_r[cnt] <= MODE_HELD;
        ACT_RELEASE: mode_r[cnt] <= MODE_REL;
        ACT_FREE:    mode_r[cnt] <= MODE_IDLE;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (upd.update) begin
      if (at_tgt) begin
        if (act == ACT_TAKE) begin
          vnote_r[cnt] <= item_note_r;
          rank_r[cnt]  <= was_held_r ? IW'(count_r - 1'b1) : IW'(count_r);
        end
      end else if (remove && rd_mode == MODE_HELD && rd_rank > rv_r) begin
        rank_r[cnt] <= rd_rank - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (upd.update && upd.last) begin
      if (act == ACT_TAKE && !was_held_r) begin
        count_r <= count_r + 1'b1;
      end else if (act == ACT_RELEASE) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.finish) begin
      out_granted_r <= (act != ACT_NONE);
      out_index_r   <= VID_W'(tgt);
      out_how_r     <= (act == ACT_TAKE) ? how : HOW_RETRIG;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_voice_index = out_index_r;
  assign out_how         = out_how_r;

endmodule

// ===== design/pva_checker.sv =====
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks on the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pva_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_granted,
  input logic [2:0] out_voice_index,
  input logic [1:0] out_how
);

  // a refused event reports voice 0 and no method
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_voice_index == 3'd0 && out_how == 2'd0)
    else $error("ungranted result carries a voice or method");

  // events are handled one at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a transfer");

  // a result cannot appear in the cycle right after the event was taken
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared without any processing");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted)
      && $stable(out_voice_index) && $stable(out_how))
    else $error("stalled result changed");

endmodule

bind polyphonic_voice_allocator pva_checker u_pva_checker (.*);

// ===== bench/tb_polyphonic_voice_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyphonic_voice_allocator
// Sends note-on, note-off and release-done events through the allocator and
// checks every grant against a voice tracker kept alongside the block. The
// sender works in bursts with gaps, the receiver stalls in changing patterns,
// and one long receiver hold-off backs the block up onto its input.
// ----------------------------------------------------------------------------
module tb_polyphonic_voice_allocator;
  import pva_pkg::*;

  localparam int NV = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic              granted;
    logic [VID_W-1:0]  idx;
    how_t              how;
  } grant_t;

  typedef enum logic [1:0] {
    RX_FREE     = 2'd0,
    RX_LIGHT    = 2'd1,
    RX_HEAVY    = 2'd2,
    RX_PERIODIC = 2'd3
  } rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_op;
  logic [NOTE_W-1:0] in_note;
  logic [VID_W-1:0]  in_voice_id;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_granted;
  logic [VID_W-1:0]  out_voice_index;
  logic [1:0]        out_how;

  // voice tracker
  mode_t             vmode [NV];
  logic [NOTE_W-1:0] vnote [NV];
  logic [VID_W-1:0]  age_list[$];

  grant_t      expected_grants[$];
  int unsigned errors = 0;
  int unsigned burst_left;
  int unsigned hold_requests;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick = 0;
  rx_mode_t    rx_mode = RX_FREE;

  polyphonic_voice_allocator #(.NUM_VOICES(NV)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_note         (in_note),
    .in_voice_id     (in_voice_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted     (out_granted),
    .out_voice_index (out_voice_index),
    .out_how         (out_how)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb_polyphonic_voice_allocator failed");
    $finish;
  end

  function automatic void drop_from_age(logic [VID_W-1:0] v);
    for (int k = 0; k < age_list.size(); k++) begin
      if (age_list[k] == v) begin
        age_list.delete(k);
        break;
      end
    end
  endfunction

  // Applies one event to the tracker and returns the grant it should produce.
  function automatic grant_t predict_grant(logic [1:0] op, logic [NOTE_W-1:0] note,
                                           logic [VID_W-1:0] vid);
    grant_t r;
    bit     found;
    bit     any;
    int     lo_i, hi_i, lo_n, hi_n;
    r = '0;
    found = 1'b0;
    any = 1'b0;
    lo_i = 0;
    hi_i = 0;
    lo_n = 128;
    hi_n = 0;
    case (op)
      OP_ON: begin
        for (int i = 0; i < NV && !found; i++) begin
          if (vmode[i] != MODE_IDLE && vnote[i] == note) begin
            found = 1'b1; r.idx = VID_W'(i); r.how = HOW_RETRIG;
          end
        end
        for (int i = 0; i < NV && !found; i++) begin
          if (vmode[i] == MODE_IDLE) begin
            found = 1'b1; r.idx = VID_W'(i); r.how = HOW_IDLE;
          end
        end
        if (!found) begin
          // lowest and highest held notes are protected from stealing
          for (int i = 0; i < NV && !found; i++) begin
            if (vmode[i] == MODE_REL) begin
              found = 1'b1; r.idx = VID_W'(i); r.how = HOW_REL;
            end else begin
              if (vnote[i] < lo_n) begin
                lo_n = vnote[i]; lo_i = i;
              end
              if (!any || vnote[i] > hi_n) begin
                hi_n = vnote[i]; hi_i = i;
              end
              any = 1'b1;
            end
          end
          for (int k = 0; k < age_list.size() && !found; k++) begin
            if (age_list[k] != lo_i && age_list[k] != hi_i) begin
              found = 1'b1; r.idx = age_list[k]; r.how = HOW_STEAL;
            end
          end
        end
        if (found) begin
          drop_from_age(r.idx);
          age_list.insert(age_list.size(), r.idx);
          vmode[r.idx] = MODE_HELD;
          vnote[r.idx] = note;
          r.granted = 1'b1;
        end else begin
          r = '0;
        end
      end
      OP_OFF: begin
        for (int i = 0; i < NV; i++) begin
          if (vmode[i] == MODE_HELD && vnote[i] == note) begin
            vmode[i] = MODE_REL;
            drop_from_age(VID_W'(i));
            r.granted = 1'b1;
            r.idx = VID_W'(i);
            break;
          end
        end
      end
      OP_DONE: begin
        if (vid < NV && vmode[vid] == MODE_REL) begin
          vmode[vid] = MODE_IDLE;
          r.granted = 1'b1;
          r.idx = vid;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one event, waits for the transfer, then either keeps valid up for
  // the rest of the burst or drops it for a random gap.
  task automatic send_event(logic [1:0] op, logic [NOTE_W-1:0] note,
                            logic [VID_W-1:0] vid);
    in_valid    <= 1'b1;
    in_op       <= op;
    in_note     <= note;
    in_voice_id <= vid;
    do @(posedge clk); while (in_stall);
    expected_grants.insert(expected_grants.size(), predict_grant(op, note, vid));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(8, 40)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  endtask

  task automatic test_directed();
    // fill all voices, with a retrigger of a held note on the way
    send_event(OP_ON, 7'd0, 3'd0);
    send_event(OP_ON, 7'd127, 3'd7);
    send_event(OP_ON, 7'd0, 3'd0);
    for (int n = 60; n < 66; n++) send_event(OP_ON, NOTE_W'(n), 3'd0);
    // all held: oldest voice that holds neither extreme gets stolen
    send_event(OP_ON, 7'd70, 3'd0);
    send_event(OP_OFF, 7'd61, 3'd0);
    send_event(OP_OFF, 7'd61, 3'd0);
    // no idle voice, so the releasing one is taken
    send_event(OP_ON, 7'd90, 3'd0);
    send_event(OP_OFF, 7'd90, 3'd0);
    // retrigger of a releasing voice
    send_event(OP_ON, 7'd90, 3'd0);
    send_event(OP_OFF, 7'd90, 3'd0);
    send_event(OP_DONE, 7'd0, 3'd3);
    send_event(OP_DONE, 7'd0, 3'd3);
    send_event(OP_DONE, 7'd0, 3'd0);
    send_event(OP_UNUSED, 7'd127, 3'd7);
    send_event(OP_OFF, 7'd127, 3'd0);
    send_event(OP_DONE, 7'd127, 3'd1);
    send_event(OP_DONE, 7'd0, 3'd7);
    send_event(OP_OFF, 7'd100, 3'd5);
  endtask

  task automatic test_random_traffic();
    int                on_pct;
    int                base;
    int                pick;
    logic [1:0]        op;
    logic [NOTE_W-1:0] note;
    logic [VID_W-1:0]  vid;
    logic [NOTE_W-1:0] held_notes[$];
    logic [VID_W-1:0]  rel_voices[$];
    for (int seg = 0; seg < 9; seg++) begin
      on_pct = $urandom_range(35, 70);
      base = $urandom_range(0, 112);
      repeat (100) begin
        held_notes.delete();
        rel_voices.delete();
        for (int i = 0; i < NV; i++) begin
          if (vmode[i] == MODE_HELD) held_notes.insert(held_notes.size(), vnote[i]);
          if (vmode[i] == MODE_REL) rel_voices.insert(rel_voices.size(), VID_W'(i));
        end
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) note = NOTE_W'($urandom_range(0, 127));
        else note = NOTE_W'(base + $urandom_range(0, 15));
        vid = VID_W'($urandom_range(0, NV - 1));
        if (pick < on_pct) begin
          op = OP_ON;
        end else if (pick < on_pct + (100 - on_pct) / 2) begin
          op = OP_OFF;
          if (held_notes.size() > 0 && $urandom_range(0, 4) != 0)
            note = held_notes[$urandom_range(0, held_notes.size() - 1)];
        end else if (pick < 96) begin
          op = OP_DONE;
          if (rel_voices.size() > 0 && $urandom_range(0, 4) != 0)
            vid = rel_voices[$urandom_range(0, rel_voices.size() - 1)];
        end else begin
          op = OP_UNUSED;
        end
        send_event(op, note, vid);
      end
    end
  endtask

  // Receiver holds off while the sender floods, so the block backs up.
  task automatic test_output_hold();
    hold_requests++;
    burst_left = 60;
    repeat (40) begin
      send_event(($urandom_range(0, 2) == 0) ? OP_OFF : OP_ON,
                 NOTE_W'($urandom_range(40, 60)), VID_W'($urandom_range(0, NV - 1)));
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(30, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_stall <= (rx_tick[2:0] < 3'd3);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, got granted=%0d voice=%0d how=%0d",
                 $time, out_granted, out_voice_index, out_how);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (out_granted !== want.granted) begin
          $display("%0t: granted mismatch: expected %0d, got %0d",
                   $time, want.granted, out_granted);
          errors++;
        end
        if (out_voice_index !== want.idx) begin
          $display("%0t: voice_index mismatch: expected %0d, got %0d",
                   $time, want.idx, out_voice_index);
          errors++;
        end
        if (out_how !== want.how) begin
          $display("%0t: how mismatch: expected %0d, got %0d",
                   $time, want.how, out_how);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_ON;
    in_note       = '0;
    in_voice_id   = '0;
    burst_left    = 0;
    hold_requests = 0;
    for (int i = 0; i < NV; i++) begin
      vmode[i] = MODE_IDLE;
      vnote[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_output_hold();

    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_polyphonic_voice_allocator passed");
    end else begin
      $display("tb_polyphonic_voice_allocator failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pva_pkg.sv
design/pva_scan.sv
design/pva_seq.sv
design/polyphonic_voice_allocator.sv
design/pva_checker.sv
bench/tb_polyphonic_voice_allocator.sv
